FILE: rtl/core/mtg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mtg_pkg
// shared constants, types and the tempering function of the mt19937 unit
// ---------------------------------------------------------------------------
package mtg_pkg;

  localparam int unsigned DEPTH       = 624;
  localparam int unsigned OFFSET      = 397;
  localparam int unsigned ADDR_W      = $clog2(DEPTH);
  localparam int unsigned NUM_KEYS    = 4;
  localparam int unsigned KEY_IDX_W   = $clog2(NUM_KEYS);
  localparam int unsigned KEY_LEN_DEF = 4;

  localparam logic [31:0] ARRAY_SEED  = 32'd19650218;
  localparam logic [31:0] MUL_SINGLE  = 32'd1812433253;
  localparam logic [31:0] MUL_MIX1    = 32'd1664525;
  localparam logic [31:0] MUL_MIX2    = 32'd1566083941;
  localparam logic [31:0] UPPER_BIT   = 32'h8000_0000;
  localparam logic [31:0] MATRIX_WORD = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B    = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C    = 32'hefc6_0000;

  localparam logic [ADDR_W-1:0] IDX_EMPTY    = ADDR_W'(DEPTH);
  localparam logic [ADDR_W-1:0] IDX_UNSEEDED = ADDR_W'(DEPTH + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    CMD_SEED_VALUE = 2'd0,
    CMD_SEED_KEYS  = 2'd1,
    CMD_DRAW       = 2'd2,
    CMD_UNUSED     = 2'd3
  } command_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SS_INIT,
    OP_SS_MUL,
    OP_SS_WR,
    OP_A_START,
    OP_A_RD,
    OP_A_WR,
    OP_A_WRAP,
    OP_A_FIN,
    OP_T_PRE,
    OP_T_LD,
    OP_T_RD,
    OP_T_WR,
    OP_D_RD,
    OP_D_OUT,
    OP_D_NS
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SS_MUL,
    ST_SS_WR,
    ST_A_START,
    ST_A_RD,
    ST_A_WR,
    ST_A_WRAP,
    ST_A_FIN,
    ST_T_PRE,
    ST_T_LD,
    ST_T_RD,
    ST_T_WR,
    ST_D_RD,
    ST_D_OUT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
    logic   loop2;
    logic   array_seed;
  } dp_cmd_t;

  typedef struct packed {
    logic n_last;
    logic k_last;
    logic unseeded;
    logic empty;
  } dp_status_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

FILE: rtl/core/mersenne_twister_generator_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mersenne_twister_generator_unit
// mt19937 generator with a 624-word state memory and command interface
// ---------------------------------------------------------------------------
// a command is taken when start_i is high and busy_o low. a draw returns one
// word on random_word_o with valid_o high for a single cycle; the receiver
// cannot stall it, so capture it when the strobe is seen. a draw reads the
// memory, then tempers the word into the output register, and busy_o stays
// high through both steps; a draw that finds the store used up first
// regenerates it word by word over the dual-read state memory. both seeding
// commands keep busy_o high until the store is written, and both run every
// word through the one shared 32x32 multiplier with a register after it.
// seeding gives no word. a draw before any seeding returns not_seeded_o high
// and a zero word on the cycle after the accept. the user must see that key
// words are written on the cfg port only while busy_o is low; the block
// itself does not enforce it.
module mersenne_twister_generator_unit #(
  parameter int unsigned KEY_WORDS = mtg_pkg::KEY_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] seed_value_i,
  input  logic        cfg_we_i,
  input  logic [mtg_pkg::KEY_IDX_W-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        valid_o,
  output logic [31:0] random_word_o,
  output logic        not_seeded_o
);
  import mtg_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  mtg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .busy_o    (busy_o),
    .cmd_o     (cmd),
    .status_i  (status)
  );

  mtg_datapath #(
    .KEY_WORDS (KEY_WORDS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .seed_value_i  (seed_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .valid_o       (valid_o),
    .random_word_o (random_word_o),
    .not_seeded_o  (not_seeded_o)
  );

`ifndef SYNTH
  // not seeded word is always zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && not_seeded_o) |-> (random_word_o == 32'd0))
    else $error("not seeded word is nonzero");

  // an ignored command leaves the unit idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i == CMD_UNUSED) |=> (!busy_o && !valid_o))
    else $error("unused command started work");

  // a seeding command never gives a word on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (command_i == CMD_SEED_VALUE || command_i == CMD_SEED_KEYS))
    |=> (busy_o && !valid_o))
    else $error("seeding gave a word");
`endif

endmodule

FILE: rtl/core/mtg_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mtg_datapath
// state memory, multiplier, counters, key registers and output registers
// ---------------------------------------------------------------------------
module mtg_datapath #(
  parameter int unsigned KEY_WORDS = mtg_pkg::KEY_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mtg_pkg::dp_cmd_t     cmd_i,
  output mtg_pkg::dp_status_t  status_o,
  input  logic [31:0]          seed_value_i,
  input  logic                 cfg_we_i,
  input  logic [mtg_pkg::KEY_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output logic                 valid_o,
  output logic [31:0]          random_word_o,
  output logic                 not_seeded_o
);
  import mtg_pkg::*;

  localparam int unsigned JW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

  logic [31:0]       mem_q [DEPTH];
  logic [31:0]       rd_a_q, rd_b_q;
  logic [ADDR_W-1:0] raddr_a, raddr_b;
  logic              mem_we;
  logic [ADDR_W-1:0] waddr;
  logic [31:0]       wdata;

  logic [31:0]       key_q [NUM_KEYS];
  logic [31:0]       p_q, p_d, prod_q, prod_d, cur_q, cur_d;
  logic [ADDR_W-1:0] n_q, n_d, k_q, k_d, idx_q, idx_d;
  logic [JW-1:0]     j_q, j_d;
  logic              valid_q, valid_d, ns_q, ns_d;
  logic [31:0]       word_q, word_d;

  logic [31:0]       mix, mul_k, seed_sel, key_sel, mixed, y, twisted;
  logic [ADDR_W-1:0] far, nxt;
  logic              n_last, k_last;

  always_comb begin
    mix      = p_q ^ (p_q >> 30);
    mul_k    = (cmd_i.op == OP_SS_MUL) ? MUL_SINGLE : (cmd_i.loop2 ? MUL_MIX2 : MUL_MIX1);
    prod_d   = mul_k * mix;
    seed_sel = cmd_i.array_seed ? ARRAY_SEED : seed_value_i;
    key_sel  = (32'(j_q) < 32'(NUM_KEYS)) ? key_q[KEY_IDX_W'(j_q)] : 32'd0;
    mixed    = cmd_i.loop2 ? ((rd_a_q ^ prod_q) - 32'(n_q))
                           : ((rd_a_q ^ prod_q) + key_sel + 32'(j_q));
    n_last   = (n_q == LAST_ADDR);
    k_last   = cmd_i.loop2 ? (k_q == ADDR_W'(DEPTH - 2)) : (k_q == LAST_ADDR);
    nxt      = n_last ? '0 : n_q + 1'b1;
    far      = (n_q >= ADDR_W'(DEPTH - OFFSET)) ? n_q - ADDR_W'(DEPTH - OFFSET)
                                                : n_q + ADDR_W'(OFFSET);
    y        = {cur_q[31], rd_a_q[30:0]};
    twisted  = rd_b_q ^ (y >> 1) ^ (y[0] ? MATRIX_WORD : 32'd0);
  end

  always_comb begin
    mem_we  = 1'b0;
    waddr   = n_q;
    wdata   = p_q;
    raddr_a = n_q;
    raddr_b = far;
    p_d     = p_q;
    cur_d   = cur_q;
    n_d     = n_q;
    k_d     = k_q;
    j_d     = j_q;
    idx_d   = idx_q;
    valid_d = 1'b0;
    ns_d    = 1'b0;
    word_d  = word_q;
    unique case (cmd_i.op)
      OP_SS_INIT: begin
        mem_we = 1'b1;
        waddr  = '0;
        wdata  = seed_sel;
        p_d    = seed_sel;
        n_d    = ADDR_W'(1);
      end
      OP_SS_WR: begin
        mem_we = 1'b1;
        wdata  = prod_q + 32'(n_q);
        p_d    = wdata;
        n_d    = n_q + 1'b1;
        if (n_last) idx_d = IDX_EMPTY;
      end
      OP_A_START: begin
        p_d = ARRAY_SEED;
        n_d = ADDR_W'(1);
        k_d = '0;
        j_d = '0;
      end
      OP_A_WR: begin
        mem_we = 1'b1;
        wdata  = mixed;
        p_d    = mixed;
        n_d    = n_last ? ADDR_W'(1) : n_q + 1'b1;
        k_d    = k_last ? '0 : k_q + 1'b1;
        j_d    = (j_q == JW'(KEY_WORDS - 1)) ? '0 : j_q + 1'b1;
      end
      OP_A_WRAP: begin
        mem_we = 1'b1;
        waddr  = '0;
      end
      OP_A_FIN: begin
        mem_we = 1'b1;
        waddr  = '0;
        wdata  = UPPER_BIT;
        idx_d  = IDX_EMPTY;
      end
      OP_T_PRE: begin
        raddr_a = '0;
        n_d     = '0;
      end
      OP_T_RD: raddr_a = nxt;
      OP_T_LD: cur_d = rd_a_q;
      OP_T_WR: begin
        mem_we = 1'b1;
        wdata  = twisted;
        cur_d  = rd_a_q;
        n_d    = n_q + 1'b1;
        if (n_last) idx_d = '0;
      end
      OP_D_RD: raddr_a = idx_q;
      OP_D_OUT: begin
        valid_d = 1'b1;
        word_d  = temper(rd_a_q);
        idx_d   = idx_q + 1'b1;
      end
      OP_D_NS: begin
        valid_d = 1'b1;
        ns_d    = 1'b1;
        word_d  = '0;
      end
      OP_NONE, OP_SS_MUL, OP_A_RD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= wdata;
    rd_a_q <= mem_q[raddr_a];
    rd_b_q <= mem_q[raddr_b];
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    prod_q <= prod_d;
    cur_q  <= cur_d;
    word_q <= word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= '0;
      k_q     <= '0;
      j_q     <= '0;
      idx_q   <= IDX_UNSEEDED;
      valid_q <= 1'b0;
      ns_q    <= 1'b0;
      for (int i = 0; i < NUM_KEYS; i++) key_q[i] <= '0;
    end else begin
      n_q     <= n_d;
      k_q     <= k_d;
      j_q     <= j_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
      ns_q    <= ns_d;
      if (cfg_we_i) key_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign status_o.n_last   = n_last;
  assign status_o.k_last   = k_last;
  assign status_o.unseeded = (idx_q == IDX_UNSEEDED);
  assign status_o.empty    = (idx_q == IDX_EMPTY);
  assign valid_o           = valid_q;
  assign random_word_o     = word_q;
  assign not_seeded_o      = ns_q;

endmodule

FILE: rtl/core/mtg_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mtg_ctrl
// sequencer for seeding, twist and draw commands
// ---------------------------------------------------------------------------
module mtg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          command_i,
  output logic                busy_o,
  output mtg_pkg::dp_cmd_t    cmd_o,
  input  mtg_pkg::dp_status_t status_i
);
  import mtg_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        array_q, array_d, loop2_q, loop2_d, kl_q, kl_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      array_q <= 1'b0;
      loop2_q <= 1'b0;
      kl_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      array_q <= array_d;
      loop2_q <= loop2_d;
      kl_q    <= kl_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    array_d          = array_q;
    loop2_d          = loop2_q;
    kl_d             = kl_q;
    cmd_o.op         = OP_NONE;
    cmd_o.loop2      = loop2_q;
    cmd_o.array_seed = array_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (command_e'(command_i))
            CMD_SEED_VALUE, CMD_SEED_KEYS: begin
              array_d          = (command_e'(command_i) == CMD_SEED_KEYS);
              cmd_o.array_seed = array_d;
              cmd_o.op         = OP_SS_INIT;
              state_d          = ST_SS_MUL;
            end
            CMD_DRAW: begin
              if (status_i.unseeded) cmd_o.op = OP_D_NS;
              else if (status_i.empty) state_d = ST_T_PRE;
              else state_d = ST_D_RD;
            end
            CMD_UNUSED: ;
            default: ;
          endcase
        end
      end
      ST_SS_MUL: begin
        cmd_o.op = OP_SS_MUL;
        state_d  = ST_SS_WR;
      end
      ST_SS_WR: begin
        cmd_o.op = OP_SS_WR;
        if (!status_i.n_last) state_d = ST_SS_MUL;
        else state_d = array_q ? ST_A_START : ST_IDLE;
      end
      ST_A_START: begin
        cmd_o.op = OP_A_START;
        loop2_d  = 1'b0;
        state_d  = ST_A_RD;
      end
      ST_A_RD: begin
        cmd_o.op = OP_A_RD;
        state_d  = ST_A_WR;
      end
      ST_A_WR: begin
        cmd_o.op = OP_A_WR;
        kl_d     = status_i.k_last;
        if (status_i.n_last) state_d = ST_A_WRAP;
        else if (!status_i.k_last) state_d = ST_A_RD;
        else if (loop2_q) state_d = ST_A_FIN;
        else begin
          loop2_d = 1'b1;
          state_d = ST_A_RD;
        end
      end
      ST_A_WRAP: begin
        cmd_o.op = OP_A_WRAP;
        if (!kl_q) state_d = ST_A_RD;
        else if (loop2_q) state_d = ST_A_FIN;
        else begin
          loop2_d = 1'b1;
          state_d = ST_A_RD;
        end
      end
      ST_A_FIN: begin
        cmd_o.op = OP_A_FIN;
        state_d  = ST_IDLE;
      end
      ST_T_PRE: begin
        cmd_o.op = OP_T_PRE;
        state_d  = ST_T_LD;
      end
      ST_T_LD: begin
        cmd_o.op = OP_T_LD;
        state_d  = ST_T_RD;
      end
      ST_T_RD: begin
        cmd_o.op = OP_T_RD;
        state_d  = ST_T_WR;
      end
      ST_T_WR: begin
        cmd_o.op = OP_T_WR;
        state_d  = status_i.n_last ? ST_D_RD : ST_T_RD;
      end
      ST_D_RD: begin
        cmd_o.op = OP_D_RD;
        state_d  = ST_D_OUT;
      end
      ST_D_OUT: begin
        cmd_o.op = OP_D_OUT;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

FILE: tb/sv/mersenne_twister_generator_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mersenne_twister_generator_unit_tb
// drives seed and draw commands into the mt19937 unit, predicts every drawn
// word with a behavioral copy of the generator and compares field by field
// ---------------------------------------------------------------------------
module mersenne_twister_generator_unit_tb;

  import mtg_pkg::*;

  localparam int unsigned N_WORDS    = 624;
  localparam int unsigned TWIST_FAR  = 397;
  localparam int unsigned KEY_LEN    = 4;
  localparam int unsigned INDEX_VOID = N_WORDS + 1;
  localparam longint      CYCLE_LIMIT = 64'd20_000_000;

  typedef struct packed {
    logic [31:0] word;
    logic        unseeded;
  } draw_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  command_i;
  logic [31:0] seed_value_i;
  logic        cfg_we_i;
  logic [KEY_IDX_W-1:0] cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        valid_o;
  logic [31:0] random_word_o;
  logic        not_seeded_o;

  // behavioral generator state
  logic [31:0] mt_store [N_WORDS];
  int unsigned mt_index;
  logic [31:0] key_reg [KEY_LEN];

  draw_word_t  expected_words [$];
  int unsigned fail_count;
  int unsigned draw_count;
  int unsigned seed_count;
  int unsigned send_idle_pct;
  longint      cycle_count;

  mersenne_twister_generator_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .seed_value_i  (seed_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .valid_o       (valid_o),
    .random_word_o (random_word_o),
    .not_seeded_o  (not_seeded_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---- generator prediction ----

  function automatic void mt_seed_value(input logic [31:0] s);
    logic [31:0] p;
    mt_store[0] = s;
    for (int unsigned n = 1; n < N_WORDS; n++) begin
      p = mt_store[n-1];
      mt_store[n] = 32'd1812433253 * (p ^ (p >> 30)) + 32'(n);
    end
    mt_index = N_WORDS;
  endfunction

  function automatic void mt_seed_keys();
    int unsigned i;
    int unsigned j;
    logic [31:0] p;
    i = 1;
    j = 0;
    mt_seed_value(32'd19650218);
    for (int unsigned k = N_WORDS; k > 0; k--) begin
      p = mt_store[i-1];
      mt_store[i] = (mt_store[i] ^ ((p ^ (p >> 30)) * 32'd1664525)) + key_reg[j] + 32'(j);
      i++;
      j++;
      if (i >= N_WORDS) begin
        mt_store[0] = mt_store[N_WORDS-1];
        i = 1;
      end
      if (j >= KEY_LEN) j = 0;
    end
    for (int unsigned k = N_WORDS - 1; k > 0; k--) begin
      p = mt_store[i-1];
      mt_store[i] = (mt_store[i] ^ ((p ^ (p >> 30)) * 32'd1566083941)) - 32'(i);
      i++;
      if (i >= N_WORDS) begin
        mt_store[0] = mt_store[N_WORDS-1];
        i = 1;
      end
    end
    mt_store[0] = 32'h8000_0000;
    mt_index = N_WORDS;
  endfunction

  function automatic void mt_regenerate();
    logic [31:0] y;
    for (int unsigned n = 0; n < N_WORDS; n++) begin
      y = (mt_store[n] & 32'h8000_0000) | (mt_store[(n+1) % N_WORDS] & 32'h7fff_ffff);
      mt_store[n] = mt_store[(n + TWIST_FAR) % N_WORDS] ^ (y >> 1)
                    ^ (y[0] ? 32'h9908_b0df : 32'h0);
    end
    mt_index = 0;
  endfunction

  function automatic draw_word_t mt_draw();
    draw_word_t r;
    logic [31:0] y;
    if (mt_index >= INDEX_VOID) begin
      r.word = '0;
      r.unseeded = 1'b1;
      return r;
    end
    if (mt_index >= N_WORDS) mt_regenerate();
    y = mt_store[mt_index];
    mt_index++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9d2c_5680);
    y = y ^ ((y << 15) & 32'hefc6_0000);
    y = y ^ (y >> 18);
    r.word = y;
    r.unseeded = 1'b0;
    return r;
  endfunction

  // ---- stimulus helpers ----

  // one command word; waits through random idle and until the unit takes it
  // start_i stays high after the accept so a following command can go
  // back to back; idle cycles and drain_unit drop it
  task automatic send_command(input command_e cmd, input logic [31:0] seed);
    cfg_we_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    command_i    <= cmd;
    seed_value_i <= seed;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    // accepted at this edge
    case (cmd)
      CMD_SEED_VALUE: begin mt_seed_value(seed); seed_count++; end
      CMD_SEED_KEYS:  begin mt_seed_keys(); seed_count++; end
      CMD_DRAW:       begin expected_words.push_back(mt_draw()); draw_count++; end
      default: ;
    endcase
  endtask

  // wait for every expected word, then let a running seed or twist finish
  task automatic drain_unit();
    start_i  <= 1'b0;
    cfg_we_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // write enable stays high for a following key write; the next command drops it
  task automatic write_key(input int unsigned idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= KEY_IDX_W'(idx);
    cfg_data_i  <= val;
    @(posedge clk_i);
    key_reg[idx] = val;
  endtask

  task automatic draw_burst(input int unsigned n);
    repeat (n) send_command(CMD_DRAW, $urandom());
  endtask

  // ---- test tasks ----

  // draws before seeding, unused command, extreme seeds, then seeding from key words
  task automatic test_directed();
    send_command(CMD_DRAW, 32'hffff_ffff);
    send_command(CMD_UNUSED, 32'h1234_5678);
    send_command(CMD_DRAW, 32'h0);
    send_command(CMD_SEED_VALUE, 32'd5489);
    draw_burst(4);
    send_command(CMD_SEED_VALUE, 32'h0);
    draw_burst(2);
    send_command(CMD_SEED_VALUE, 32'hffff_ffff);
    draw_burst(2);
    send_command(CMD_UNUSED, 32'hffff_ffff);
    draw_burst(1);
    drain_unit();
    // default key words (all zero), then the classic key set
    send_command(CMD_SEED_KEYS, 32'h0);
    draw_burst(2);
    drain_unit();
    write_key(0, 32'h123);
    write_key(1, 32'h234);
    write_key(2, 32'h345);
    write_key(3, 32'h456);
    send_command(CMD_SEED_KEYS, $urandom());
    draw_burst(3);
    drain_unit();
  endtask

  // crosses the regeneration boundary of the store more than once
  task automatic test_regenerate();
    send_command(CMD_SEED_VALUE, $urandom());
    draw_burst(N_WORDS + 20);
    drain_unit();
  endtask

  // key words at extremes and random, with seeds and draws mixed in
  task automatic test_random(input int unsigned n_items);
    int unsigned pick;
    for (int unsigned phase = 0; phase < 3; phase++) begin
      for (int unsigned k = 0; k < KEY_LEN; k++)
        write_key(k, (phase == 0) ? 32'hffff_ffff : (phase == 1) ? 32'h0 : $urandom());
      for (int unsigned n = 0; n < n_items / 3; n++) begin
        pick = $urandom_range(99);
        if (pick < 2)      send_command(CMD_SEED_KEYS, $urandom());
        else if (pick < 6) send_command(CMD_SEED_VALUE, $urandom());
        else if (pick < 8) send_command(CMD_UNUSED, $urandom());
        else               send_command(CMD_DRAW, $urandom());
      end
      drain_unit();
    end
  endtask

  // ---- result check ----
  always @(posedge clk_i) begin
    draw_word_t exp_w;
    if (rst_ni && valid_o) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: random_word=%h not_seeded=%b", random_word_o, not_seeded_o);
        fail_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (random_word_o !== exp_w.word) begin
          $error("random_word expected %h actual %h", exp_w.word, random_word_o);
          fail_count++;
        end
        if (not_seeded_o !== exp_w.unseeded) begin
          $error("not_seeded expected %b actual %b", exp_w.unseeded, not_seeded_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mersenne_twister_generator_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    start_i      = 1'b0;
    command_i    = CMD_UNUSED;
    seed_value_i = '0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    fail_count   = 0;
    draw_count   = 0;
    seed_count   = 0;
    cycle_count  = 0;
    send_idle_pct = 23;
    mt_index     = INDEX_VOID;
    for (int unsigned k = 0; k < KEY_LEN; k++) key_reg[k] = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_regenerate();
    send_idle_pct = 23;
    test_random(60);
    send_idle_pct = 71;
    test_random(60);
    send_idle_pct = 0;
    test_random(60);

    drain_unit();
    if (expected_words.size() != 0) fail_count++;
    $display("covered %0d draws and %0d seedings across key sets and idle mixes",
             draw_count, seed_count);
    if (fail_count == 0) begin
      $display("mersenne_twister_generator_unit_tb: PASS");
    end else begin
      $display("mersenne_twister_generator_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
